// ===== hw/rtl/fpq_pkg.sv =====
// Shared types and constants of the two-queue pairing block.
`default_nettype none
package fpq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ID_BITS     = 10;
  localparam int S_DATA_W    = ((ID_BITS + 7) / 8) * 8;
  localparam int M_DATA_W    = ((2 * ID_BITS + 7) / 8) * 8;

  typedef logic [ID_BITS-1:0]  id_t;
  typedef logic [S_DATA_W-1:0] s_data_t;
  typedef logic [M_DATA_W-1:0] m_data_t;

  typedef enum logic [1:0] {
    OP_ADD_REQ = 2'd0,
    OP_ADD_SRV = 2'd1,
    OP_MATCH   = 2'd2,
    OP_CANCEL  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_MATCHED  = 2'd1,
    ST_NO_MATCH = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_POP,
    CMD_KILL,
    CMD_COMPACT
  } cell_cmd_e;

  typedef struct packed {
    logic head_valid;
    logic full;
    logic settled;
  } chain_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fpq_cell.sv =====
// One queue cell: holds an identifier and its valid bit and trades with its neighbors.
`default_nettype none
module fpq_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  fpq_pkg::cell_cmd_e     cmd_i,
  input  fpq_pkg::id_t           id_i,
  input  wire logic              prev_valid_i,
  input  wire logic              next_valid_i,
  input  fpq_pkg::id_t           next_data_i,
  output logic                   valid_o,
  output fpq_pkg::id_t           data_o
);
  import fpq_pkg::*;

  logic valid_q, valid_d;
  id_t  data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    unique case (cmd_i)
      CMD_PUSH: begin
        if (!valid_q && prev_valid_i) begin
          valid_d = 1'b1;
          data_d  = id_i;
        end
      end
      CMD_POP: begin
        valid_d = next_valid_i;
        data_d  = next_data_i;
      end
      CMD_KILL: begin
        if (valid_q && (data_q == id_i)) begin
          valid_d = 1'b0;
        end
      end
      CMD_COMPACT: begin
        // A hole pulls its successor in; a word pulled by an earlier hole leaves.
        if (!valid_q) begin
          valid_d = next_valid_i;
          data_d  = next_data_i;
        end else if (!prev_valid_i) begin
          valid_d = 1'b0;
        end
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ===== hw/rtl/fpq_chain.sv =====
// A row of queue cells forming one order-preserving queue with its head at cell zero.
`default_nettype none
module fpq_chain (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  fpq_pkg::cell_cmd_e   cmd_i,
  input  fpq_pkg::id_t         id_i,
  output fpq_pkg::id_t         head_data_o,
  output fpq_pkg::chain_stat_t stat_o
);
  import fpq_pkg::*;

  logic                   valid [QUEUE_DEPTH];
  id_t                    data  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-2:0] hole;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic prev_valid;
    logic next_valid;
    id_t  next_data;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = valid[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_data  = '0;
    end else begin : g_inner
      assign next_valid = valid[i+1];
      assign next_data  = data[i+1];
      assign hole[i]    = !valid[i] && valid[i+1];
    end

    fpq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd_i),
      .id_i         (id_i),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_data_i  (next_data),
      .valid_o      (valid[i]),
      .data_o       (data[i])
    );
  end

  assign head_data_o       = data[0];
  assign stat_o.head_valid = valid[0];
  assign stat_o.full       = valid[QUEUE_DEPTH-1];
  assign stat_o.settled    = ~|hole;

endmodule
`default_nettype wire

// ===== hw/rtl/fifo_pairing_queue_with_cancel_top.sv =====
// Top level of the two-queue pairing block with requester cancel.
//
// The slave stream takes one command word per handshake: s_axis_tuser_i holds
// the opcode and s_axis_tdata_i the identifier. The master stream returns one
// result word for every command: m_axis_tuser_o holds the status and
// m_axis_tdata_o the matched server and requester identifiers.
// Each queue is a row of QUEUE_DEPTH cells with its head in cell zero.
// A result appears in the cycle after its command is taken and sits in an output
// register, so the next command can be taken in the same cycle as that word is.
// Add and match commands sustain one word per cycle while the receiver keeps up.
// A cancel clears the matching cells and then closes the holes,
// each hole moving one cell toward the tail per cycle, so the slave side stays
// stalled after a cancel until no hole is left in the requester queue.
// When the receiver stalls, the result word holds and no new command is taken
// until the output register can be refilled.
// Reset empties both queues and the output register; it takes effect at once.
`default_nettype none
module fifo_pairing_queue_with_cancel_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  fpq_pkg::s_data_t      s_axis_tdata_i,  // [9:0] entity_id, upper bits zero
  input  wire logic [1:0]       s_axis_tuser_i,  // [1:0] opcode
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output fpq_pkg::m_data_t      m_axis_tdata_o,  // [9:0] server_id, [19:10] requester_id
  output logic [1:0]            m_axis_tuser_o   // [1:0] status
);
  import fpq_pkg::*;

  typedef enum logic {
    ST_RUN,
    ST_COMPACT
  } state_e;

  state_e      state_q, state_d;
  logic        m_valid_q, m_valid_d;
  status_e     status_q, status_d;
  id_t         srv_q, srv_d;
  id_t         req_q, req_d;

  cell_cmd_e   req_cmd, srv_cmd;
  chain_stat_t req_stat, srv_stat;
  id_t         req_head, srv_head;
  id_t         in_id;
  opcode_e     opcode;
  logic        accept;
  logic        both_ready;

  assign in_id      = s_axis_tdata_i[ID_BITS-1:0];
  assign opcode     = opcode_e'(s_axis_tuser_i);
  assign both_ready = req_stat.head_valid && srv_stat.head_valid;

  assign s_axis_tready_o = (state_q == ST_RUN) && (!m_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    req_cmd   = CMD_HOLD;
    srv_cmd   = CMD_HOLD;
    state_d   = state_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    status_d  = status_q;
    srv_d     = srv_q;
    req_d     = req_q;
    if (state_q == ST_COMPACT) begin
      req_cmd = CMD_COMPACT;
      if (req_stat.settled) begin
        state_d = ST_RUN;
      end
    end else if (accept) begin
      m_valid_d = 1'b1;
      status_d  = ST_ACCEPTED;
      srv_d     = '0;
      req_d     = '0;
      unique case (opcode)
        OP_ADD_REQ: begin
          if (req_stat.full) begin
            status_d = ST_FULL;
          end else begin
            req_cmd = CMD_PUSH;
          end
        end
        OP_ADD_SRV: begin
          if (srv_stat.full) begin
            status_d = ST_FULL;
          end else begin
            srv_cmd = CMD_PUSH;
          end
        end
        OP_MATCH: begin
          if (both_ready) begin
            req_cmd  = CMD_POP;
            srv_cmd  = CMD_POP;
            status_d = ST_MATCHED;
            srv_d    = srv_head;
            req_d    = req_head;
          end else begin
            status_d = ST_NO_MATCH;
          end
        end
        OP_CANCEL: begin
          req_cmd = CMD_KILL;
          state_d = ST_COMPACT;
        end
        default: begin
          status_d = ST_ACCEPTED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_RUN;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    srv_q    <= srv_d;
    req_q    <= req_d;
  end

  fpq_chain u_req_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (req_cmd),
    .id_i        (in_id),
    .head_data_o (req_head),
    .stat_o      (req_stat)
  );

  fpq_chain u_srv_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (srv_cmd),
    .id_i        (in_id),
    .head_data_o (srv_head),
    .stat_o      (srv_stat)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = m_data_t'({req_q, srv_q});

  a_compact_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMPACT) |-> !s_axis_tready_o)
    else $error("command taken while the requester queue is compacting");

  a_compact_until_settled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_COMPACT) && !req_stat.settled) |=> (state_q == ST_COMPACT))
    else $error("compaction ended with holes left in the requester queue");

  a_cancel_starts_compact : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode == OP_CANCEL)) |=> (state_q == ST_COMPACT) && m_valid_q)
    else $error("cancel did not enter compaction with a result word");

  a_match_pops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode == OP_MATCH) && both_ready) |=>
      (m_valid_q && (status_q == ST_MATCHED)))
    else $error("match with both queues filled did not report a pair");

  a_ids_zero_unmatched : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (status_q != ST_MATCHED)) |-> ((srv_q == '0) && (req_q == '0)))
    else $error("identifiers nonzero on a result without a pair");

endmodule
`default_nettype wire
